// File: rtl/core/crc8cfr_pkg.sv
`default_nettype none

package crc8cfr_pkg;

    // Frame and request bytes
    localparam logic [7:0] FRAME_MARK = 8'h55;
    localparam logic [7:0] IDENT_REQ  = 8'h53;   // 'S'

    // CRC-8, MSB first, no final xor
    localparam logic [7:0] CRC_POLY   = 8'hE5;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_MSB    = 8'h80;

    // At most five field bytes are captured per frame
    localparam logic [2:0] MAX_FIELDS = 3'd5;

    // Ident reply "RDRV01"
    localparam logic [7:0] ID_CHAR_R    = 8'h52;
    localparam logic [7:0] ID_CHAR_D    = 8'h44;
    localparam logic [7:0] ID_CHAR_V    = 8'h56;
    localparam logic [7:0] ID_CHAR_0    = 8'h30;
    localparam logic [7:0] ID_CHAR_1    = 8'h31;
    localparam logic [2:0] IDENT_LAST   = 3'd5;

    // Field slots inside a frame
    localparam logic [2:0] SLOT_COMMAND  = 3'd0;
    localparam logic [2:0] SLOT_SEQUENCE = 3'd1;
    localparam logic [2:0] SLOT_PARAM_A  = 3'd2;
    localparam logic [2:0] SLOT_PARAM_B  = 3'd3;

    typedef enum logic [1:0] {
        KIND_CMD_OK  = 2'd0,
        KIND_CRC_BAD = 2'd1,
        KIND_NO_SYNC = 2'd2,
        KIND_IDENT   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command;
        logic [7:0] sequence_res;
        logic [7:0] param_a;
        logic [7:0] param_b;
        logic [7:0] param_c;
        logic [7:0] detail;
    } res_t;

    // One byte through the CRC register, eight shifts unrolled
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_MSB) != 8'h00) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Character of the ident reply at a given position
    function automatic logic [7:0] ident_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = ID_CHAR_R;
            3'd1:    c = ID_CHAR_D;
            3'd2:    c = ID_CHAR_R;
            3'd3:    c = ID_CHAR_V;
            3'd4:    c = ID_CHAR_0;
            3'd5:    c = ID_CHAR_1;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/crc8cfr_parser.sv
`default_nettype none

module crc8cfr_parser
    import crc8cfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       rx_beat,
    input  wire logic [7:0] rx_byte,
    output      logic       res_valid,
    output      res_t       res
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEN    = 4'b0010,
        PH_FIELDS = 4'b0100,
        PH_CRC    = 4'b1000
    } phase_t;

    phase_t     phase_reg,    phase_next;
    logic [7:0] crc_reg,      crc_next;
    logic [2:0] want_reg,     want_next;
    logic [2:0] seen_reg,     seen_next;
    logic [7:0] command_reg,  command_next;
    logic [7:0] sequence_reg, sequence_next;
    logic [7:0] param_a_reg,  param_a_next;
    logic [7:0] param_b_reg,  param_b_next;
    logic [7:0] param_c_reg,  param_c_next;

    logic [7:0] crc_step;
    logic [2:0] seen_inc;

    assign crc_step = crc8_step(crc_reg, rx_byte);
    assign seen_inc = seen_reg + 3'd1;

    // Parse one byte: next frame state and the result it causes
    always_comb begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        want_next     = want_reg;
        seen_next     = seen_reg;
        command_next  = command_reg;
        sequence_next = sequence_reg;
        param_a_next  = param_a_reg;
        param_b_next  = param_b_reg;
        param_c_next  = param_c_reg;
        res_valid     = 1'b0;
        res           = '0;

        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == IDENT_REQ) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_IDENT;
                end else if (rx_byte == FRAME_MARK) begin
                    if (rx_beat) begin
                        crc_next   = crc8_step(CRC_INIT, rx_byte);
                        phase_next = PH_LEN;
                    end
                end else begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_NO_SYNC;
                    res.detail = rx_byte;
                end
            end
            PH_LEN: begin
                if (rx_beat) begin
                    crc_next  = crc_step;
                    seen_next = 3'd0;
                    if (rx_byte > 8'(MAX_FIELDS)) begin
                        want_next = MAX_FIELDS;
                    end else begin
                        want_next = rx_byte[2:0];
                    end
                    phase_next = (rx_byte == 8'h00) ? PH_CRC : PH_FIELDS;
                end
            end
            PH_FIELDS: begin
                if (rx_beat) begin
                    crc_next = crc_step;
                    case (seen_reg)
                        SLOT_COMMAND:  command_next  = rx_byte;
                        SLOT_SEQUENCE: sequence_next = rx_byte;
                        SLOT_PARAM_A:  param_a_next  = rx_byte;
                        SLOT_PARAM_B:  param_b_next  = rx_byte;
                        default:       param_c_next  = rx_byte;
                    endcase
                    seen_next = seen_inc;
                    if (seen_inc >= want_reg) begin
                        phase_next = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                res_valid        = 1'b1;
                res.command      = command_reg;
                res.sequence_res = sequence_reg;
                res.param_a      = param_a_reg;
                res.param_b      = param_b_reg;
                res.param_c      = param_c_reg;
                if (rx_byte == crc_reg) begin
                    res.kind = KIND_CMD_OK;
                end else begin
                    res.kind   = KIND_CRC_BAD;
                    res.detail = crc_reg;
                end
                // Drop the frame and return to idle
                if (rx_beat) begin
                    phase_next    = PH_IDLE;
                    crc_next      = CRC_INIT;
                    want_next     = 3'd0;
                    seen_next     = 3'd0;
                    command_next  = 8'h00;
                    sequence_next = 8'h00;
                    param_a_next  = 8'h00;
                    param_b_next  = 8'h00;
                    param_c_next  = 8'h00;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            crc_reg      <= CRC_INIT;
            want_reg     <= 3'd0;
            seen_reg     <= 3'd0;
            command_reg  <= 8'h00;
            sequence_reg <= 8'h00;
            param_a_reg  <= 8'h00;
            param_b_reg  <= 8'h00;
            param_c_reg  <= 8'h00;
        end else begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            want_reg     <= want_next;
            seen_reg     <= seen_next;
            command_reg  <= command_next;
            sequence_reg <= sequence_next;
            param_a_reg  <= param_a_next;
            param_b_reg  <= param_b_next;
            param_c_reg  <= param_c_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/crc8cfr_out.sv
`default_nettype none

module crc8cfr_out
    import crc8cfr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t push_res,
    output      logic push_ready,
    output      logic m_tvalid,
    input  wire logic m_tready,
    output      res_t m_res,
    output      logic m_tlast
);

    logic       out_valid_reg,  out_valid_next;
    res_t       out_res_reg,    out_res_next;
    logic       last_reg,       last_next;
    logic [2:0] idx_reg,        idx_next;
    logic       pend_valid_reg, pend_valid_next;
    res_t       pend_res_reg,   pend_res_next;

    logic       out_free;
    logic       advance;
    logic [2:0] idx_inc;
    res_t       load_res;

    assign out_free   = !out_valid_reg || (m_tready && last_reg);
    assign advance    = out_valid_reg && m_tready && !last_reg;
    assign idx_inc    = idx_reg + 3'd1;
    assign load_res   = pend_valid_reg ? pend_res_reg : push_res;
    assign push_ready = !pend_valid_reg;

    // Step through ident beats, refill from the skid entry or the parser
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;

        if (advance) begin
            idx_next            = idx_inc;
            out_res_next.detail = ident_char(idx_inc);
            last_next           = (idx_inc == IDENT_LAST);
        end else if (out_free) begin
            if (pend_valid_reg || push) begin
                out_valid_next = 1'b1;
                out_res_next   = load_res;
                idx_next       = 3'd0;
                if (load_res.kind == KIND_IDENT) begin
                    out_res_next.detail = ident_char(3'd0);
                    last_next           = 1'b0;
                end else begin
                    last_next = 1'b1;
                end
                pend_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end

        // Park a new result while the output register is busy
        if (push && !(out_free && !pend_valid_reg)) begin
            pend_valid_next = 1'b1;
            pend_res_next   = push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            idx_reg        <= 3'd0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            last_reg       <= last_next;
            idx_reg        <= idx_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_res_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/crc8_command_frame_receiver.sv
// A result beat is registered in the output register, or parked in the skid entry while it is busy.
// Throughput: one byte per cycle while s_tready is high; the parser state and an unrolled CRC-8 step set this.
// An ident request gives six result beats; one skid entry behind the output register
// lets input continue while they drain, and s_tready drops only when that entry is full.
// Reset (aresetn low, synchronous): parser idle, CRC at 0xFF, held fields cleared, no beats.
`default_nettype none

module crc8_command_frame_receiver
    import crc8cfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata,   // [7:0] command, [15:8] sequence_res,
                                        // [23:16] param_a, [31:24] param_b,
                                        // [39:32] param_c, [47:40] detail
    output      logic [1:0]  m_tuser,   // [1:0] kind
    output      logic        m_tlast    // last
);

    logic rx_beat;
    logic res_valid;
    res_t res;
    res_t m_res;

    assign rx_beat = s_tvalid && s_tready;

    crc8cfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_beat   (rx_beat),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    crc8cfr_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rx_beat && res_valid),
        .push_res   (res),
        .push_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res),
        .m_tlast    (m_tlast)
    );

    // Pack result fields, lowest first
    assign m_tdata = {m_res.detail, m_res.param_c, m_res.param_b, m_res.param_a,
                      m_res.sequence_res, m_res.command};
    assign m_tuser = m_res.kind;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import crc8cfr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int ITEM_TARGET   = 250;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_LEN    = 2'd1,
        RX_FIELDS = 2'd2,
        RX_CRC    = 2'd3
    } rx_phase_t;

    typedef enum int {
        TRAILER_GOOD,
        TRAILER_WRONG,
        TRAILER_NONE
    } trailer_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] command;
        logic [7:0] sequence_res;
        logic [7:0] param_a;
        logic [7:0] param_b;
        logic [7:0] param_c;
        logic [7:0] detail;
        logic       last;
    } frame_result_t;

    // Tracks the frame parser and holds the result beats still owed by the block
    class frame_scoreboard;
        rx_phase_t     phase;
        logic [7:0]    crc;
        logic [7:0]    frame_len;
        int            seen;
        logic [7:0]    held [5];
        logic [7:0]    ident_text [6];
        frame_result_t owed [$];
        int            errors;

        function new();
            ident_text = '{ID_CHAR_R, ID_CHAR_D, ID_CHAR_R, ID_CHAR_V, ID_CHAR_0, ID_CHAR_1};
            phase  = RX_IDLE;
            errors = 0;
            clear_frame();
        endfunction

        // Bit-serial CRC-8, MSB first
        static function logic [7:0] crc_fold(logic [7:0] acc, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb  = acc[7] ^ b[i];
                acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return acc;
        endfunction

        function void clear_frame();
            crc       = CRC_INIT;
            frame_len = 8'h00;
            seen      = 0;
            foreach (held[i]) held[i] = 8'h00;
        endfunction

        function void owe(kind_t k, logic [7:0] detail, logic last);
            frame_result_t r;
            r.kind         = k;
            r.command      = held[0];
            r.sequence_res = held[1];
            r.param_a      = held[2];
            r.param_b      = held[3];
            r.param_c      = held[4];
            r.detail       = detail;
            r.last         = last;
            owed.push_back(r);
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(logic [7:0] b);
            int want;
            case (phase)
                RX_IDLE: begin
                    if (b == IDENT_REQ) begin
                        for (int k = 0; k < 6; k++) owe(KIND_IDENT, ident_text[k], k == 5);
                    end else if (b == FRAME_MARK) begin
                        clear_frame();
                        crc   = crc_fold(CRC_INIT, b);
                        phase = RX_LEN;
                    end else begin
                        owe(KIND_NO_SYNC, b, 1'b1);
                    end
                end
                RX_LEN: begin
                    crc       = crc_fold(crc, b);
                    frame_len = b;
                    seen      = 0;
                    phase     = (b == 8'h00) ? RX_CRC : RX_FIELDS;
                end
                RX_FIELDS: begin
                    crc = crc_fold(crc, b);
                    held[(seen < 4) ? seen : 4] = b;
                    seen++;
                    want = (frame_len > 5) ? 5 : int'(frame_len);
                    if (seen >= want) phase = RX_CRC;
                end
                default: begin
                    if (b == crc) owe(KIND_CMD_OK, 8'h00, 1'b1);
                    else          owe(KIND_CRC_BAD, crc, 1'b1);
                    clear_frame();
                    phase = RX_IDLE;
                end
            endcase
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            end
        endfunction

        // Compare one result beat with the oldest owed result
        function void check_beat(logic [47:0] data, logic [1:0] user, logic last);
            frame_result_t r;
            if (owed.size() == 0) begin
                errors++;
                $error("result beat 0x%012h with nothing owed", data);
                return;
            end
            r = owed.pop_front();
            match_field("kind",         {6'd0, r.kind},  {6'd0, user});
            match_field("command",      r.command,       data[7:0]);
            match_field("sequence_res", r.sequence_res,  data[15:8]);
            match_field("param_a",      r.param_a,       data[23:16]);
            match_field("param_b",      r.param_b,       data[31:24]);
            match_field("param_c",      r.param_c,       data[39:32]);
            match_field("detail",       r.detail,        data[47:40]);
            match_field("last",         {7'd0, r.last},  {7'd0, last});
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // [7:0] command, [15:8] sequence_res, [23:16] param_a,
                              // [31:24] param_b, [39:32] param_c, [47:40] detail
    logic [1:0]  m_tuser;     // [1:0] kind
    logic        m_tlast;     // last

    frame_scoreboard sb;
    int              bytes_sent;
    int              burst_left;
    int              cycles;
    bit              hold_off_req;
    logic [7:0]      field_buf [5];

    crc8_command_frame_receiver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Offer one byte, opening a new burst after a random gap when the current one runs out
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
        sb.note_byte(b);
    endtask

    // Send marker, length, the given number of fields from field_buf and a trailer
    task automatic send_frame(input logic [7:0] len, input int n_fields, input trailer_t trailer);
        logic [7:0] c;
        c = frame_scoreboard::crc_fold(CRC_INIT, FRAME_MARK);
        send_byte(FRAME_MARK);
        c = frame_scoreboard::crc_fold(c, len);
        send_byte(len);
        for (int i = 0; i < n_fields; i++) begin
            c = frame_scoreboard::crc_fold(c, field_buf[i]);
            send_byte(field_buf[i]);
        end
        case (trailer)
            TRAILER_GOOD:  send_byte(c);
            TRAILER_WRONG: send_byte(c ^ 8'($urandom_range(1, 255)));
            default: ;
        endcase
    endtask

    // Hold the input idle until every owed result has come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [7:0] random_field();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return FRAME_MARK;
        if (pick == 1) return IDENT_REQ;
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: stall patterns that change over time, plus a long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int phase_cnt;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        phase_cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 96);
                end
                mode_left--;
                phase_cnt++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ((phase_cnt % 4) == 0);
                    default: m_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
    end

    // Run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin
        int       pick;
        int       len;
        bit       held_once;
        bit       paused_once;
        trailer_t trailer;

        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        hold_off_req = 1'b0;
        bytes_sent   = 0;
        burst_left   = 0;
        held_once    = 1'b0;
        paused_once  = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: ident request, stray bytes at the extremes
        send_byte(IDENT_REQ);
        send_byte(8'h00);
        send_byte(8'hFF);

        // Empty frame, trailer follows the length at once
        send_frame(8'h00, 0, TRAILER_GOOD);

        // Full frame with marker and ident bytes carried as data
        field_buf = '{8'h00, 8'hFF, FRAME_MARK, IDENT_REQ, 8'hA5};
        send_frame(8'h05, 5, TRAILER_GOOD);

        // One-field frame with a wrong trailer
        field_buf = '{8'h3C, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(8'h01, 1, TRAILER_WRONG);

        // Oversized length: only five fields are read
        field_buf = '{8'h81, 8'h7E, 8'h01, 8'hFE, 8'h5A};
        send_frame(8'hFF, 5, TRAILER_GOOD);
        drain_results();

        // Random: mostly well-formed frames, some broken ones, ident requests and noise
        while (bytes_sent < ITEM_TARGET) begin
            if (!held_once && bytes_sent >= 90) begin
                held_once    = 1'b1;
                hold_off_req = 1'b1;
                burst_left   = 40;
                repeat (12) send_byte(IDENT_REQ);
                drain_results();
            end
            if (!paused_once && bytes_sent >= 170) begin
                paused_once = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                pick = $urandom_range(0, 99);
                if (pick < 15)      len = 0;
                else if (pick < 80) len = $urandom_range(1, 5);
                else                len = $urandom_range(6, 255);
                foreach (field_buf[i]) field_buf[i] = random_field();
                trailer = ($urandom_range(0, 99) < 75) ? TRAILER_GOOD : TRAILER_WRONG;
                if ($urandom_range(0, 7) == 0) begin
                    // Broken frame: cut it short, the bytes after it land inside it
                    send_frame(8'(len), (len > 5) ? $urandom_range(0, 4)
                                                  : $urandom_range(0, len), TRAILER_NONE);
                end else begin
                    send_frame(8'(len), (len > 5) ? 5 : len, trailer);
                end
            end else if (pick < 90) begin
                send_byte(IDENT_REQ);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        // Wind down and report
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
